// File: src/bblt_pkg.sv
// Shared types and constants for the byte-budget LRU tile tracker.
package bblt_pkg;

  localparam int ENTRIES = 16;
  localparam int CLIENTS = 8;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CL_W    = $clog2(CLIENTS);
  localparam int APP_W   = 4;
  localparam logic [31:0] MAX_BYTES_RST = 32'd83886080;

  localparam logic [2:0] K_LOOKUP = 3'd0;
  localparam logic [2:0] K_INSERT = 3'd1;
  localparam logic [2:0] K_REMOVE = 3'd2;
  localparam logic [2:0] K_DELETE = 3'd3;
  localparam logic [2:0] K_CREATE = 3'd4;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_MISS     = 3'd1,
    ST_NOCLIENT = 3'd2,
    ST_TOOBIG   = 3'd3,
    ST_NOFREE   = 3'd4,
    ST_EVICT    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_REPLY, OP_CREATE, OP_HIT, OP_REMOVE,
    OP_DROP_DUP, OP_SCAN, OP_KILL, OP_EVICT, OP_PLACE
  } dp_op_e;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_KILL, S_EVICT, S_PLACE
  } state_e;

  typedef struct packed {
    dp_op_e  op;
    status_e st;
  } dp_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic [2:0] kind;
    logic       client_ok;
    logic       hit;
    logic       too_big;
    logic       over;
    logic       empty;
    logic       full;
    logic       scan_last;
  } dp_stat_t;

endpackage

// File: src/bblt_ctrl.sv
// Request sequencer for the tile tracker.
module bblt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bblt_pkg::dp_stat_t stat_i,
  output bblt_pkg::dp_cmd_t  cmd_o
);
  import bblt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        if (stat_i.out_free) begin
          if (stat_i.kind == K_DELETE && stat_i.client_ok) state_d = S_SCAN;
          else if (stat_i.kind == K_INSERT && stat_i.client_ok && !stat_i.too_big)
            state_d = S_EVICT;
          else state_d = S_IDLE;
        end
      end
      S_SCAN: if (stat_i.scan_last) state_d = S_KILL;
      S_KILL: if (stat_i.out_free) state_d = S_IDLE;
      S_EVICT: begin
        if (stat_i.over && !stat_i.empty) state_d = S_EVICT;
        else if (!stat_i.full) state_d = S_PLACE;
        else if (stat_i.out_free) state_d = S_PLACE;
      end
      S_PLACE: if (stat_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.st   = ST_DONE;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: if (in_valid_i) cmd_o.op = OP_LATCH;
      S_DECODE: begin
        if (stat_i.out_free) begin
          if (stat_i.kind == K_CREATE) begin
            cmd_o.op = OP_CREATE;
          end else if (stat_i.kind > K_CREATE) begin
            cmd_o.op = OP_NONE;
          end else if (!stat_i.client_ok) begin
            cmd_o.op = OP_REPLY;
            cmd_o.st = ST_NOCLIENT;
          end else if (stat_i.kind == K_LOOKUP || stat_i.kind == K_REMOVE) begin
            if (stat_i.hit) begin
              cmd_o.op = (stat_i.kind == K_LOOKUP) ? OP_HIT : OP_REMOVE;
            end else begin
              cmd_o.op = OP_REPLY;
              cmd_o.st = ST_MISS;
            end
          end else if (stat_i.kind == K_INSERT) begin
            if (stat_i.too_big) begin
              cmd_o.op = OP_REPLY;
              cmd_o.st = ST_TOOBIG;
            end else if (stat_i.hit) begin
              cmd_o.op = OP_DROP_DUP;
            end
          end
        end
      end
      S_SCAN: cmd_o.op = OP_SCAN;
      S_KILL: if (stat_i.out_free) cmd_o.op = OP_KILL;
      S_EVICT: begin
        // evict for budget first, then once more if the table is full
        if (stat_i.out_free && ((stat_i.over && !stat_i.empty) || stat_i.full))
          cmd_o.op = OP_EVICT;
      end
      S_PLACE: if (stat_i.out_free) cmd_o.op = OP_PLACE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// File: src/bblt_dpath.sv
// Tile table, client registry, byte count and output word register.
module bblt_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bblt_pkg::dp_cmd_t  cmd_i,
  output bblt_pkg::dp_stat_t stat_o,
  input  logic [31:0]       max_bytes_i,
  input  logic [2:0]        kind_i,
  input  logic [3:0]        app_id_i,
  input  logic signed [31:0] tile_x_i,
  input  logic signed [31:0] tile_y_i,
  input  logic signed [31:0] tile_z_i,
  input  logic [4:0]        res_level_i,
  input  logic [24:0]       tile_bytes_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [3:0]        out_app_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [4:0]        out_res_o,
  output logic [31:0]       used_bytes_o,
  output logic              last_o
);
  import bblt_pkg::*;

  // latched request
  logic [2:0]  kind_q;
  logic [3:0]  app_q;
  logic [31:0] x_q, y_q, z_q;
  logic [4:0]  lvl_q;
  logic [24:0] size_q;

  // table
  logic [ENTRIES-1:0] vld_q, vld_d;
  logic [3:0]  cli_q  [ENTRIES];
  logic [31:0] ox_q   [ENTRIES];
  logic [31:0] oy_q   [ENTRIES];
  logic [31:0] oz_q   [ENTRIES];
  logic [4:0]  lv_q   [ENTRIES];
  logic [24:0] sz_q   [ENTRIES];
  logic [IDX_W-1:0] age_q [ENTRIES];
  logic [IDX_W-1:0] age_d [ENTRIES];

  logic [CLIENTS-1:0] live_q, live_d;
  logic [3:0]         next_q, next_d;
  logic [31:0]        bytes_q, bytes_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   scan_q, scan_d;

  logic        out_valid_q;
  logic [2:0]  st_q;
  logic [3:0]  oapp_q;
  logic [31:0] ox_o_q, oy_o_q, oz_o_q;
  logic [4:0]  ores_q;
  logic [31:0] used_q;
  logic        last_q;

  logic [ENTRIES-1:0] match;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx, old_idx, free_idx, drop_idx;
  logic               drop_en, place_en, out_load;
  logic [IDX_W-1:0]   drop_age;
  logic [24:0]        drop_size;
  logic [31:0]        bytes_sub;
  logic [3:0]         app_m1, next_m1;
  logic               client_ok, next_ok;
  logic               out_free;
  logic [2:0]         ost;
  logic [3:0]         oapp;
  logic [31:0]        ox, oy, oz;
  logic [4:0]         ores;
  logic               olast;

  assign out_free = !out_valid_q || !out_stall_i;
  assign app_m1   = app_q - 4'd1;
  assign next_m1  = next_q - 4'd1;
  assign client_ok = (app_q != 4'd0) && ({28'd0, app_q} <= 32'(CLIENTS))
                     && live_q[app_m1[CL_W-1:0]];
  assign next_ok  = (next_q != 4'd0) && ({28'd0, next_q} <= 32'(CLIENTS));

  always_comb begin
    hit_idx  = '0;
    old_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = vld_q[i] && cli_q[i] == app_q && ox_q[i] == x_q && oy_q[i] == y_q
                 && oz_q[i] == z_q && lv_q[i] == lvl_q;
      if (match[i]) hit_idx = IDX_W'(i);
      if (vld_q[i] && age_q[i] == '0) old_idx = IDX_W'(i);
      if (!vld_q[i]) free_idx = IDX_W'(i);
    end
    hit = |match;
  end

  always_comb begin
    drop_en  = 1'b0;
    drop_idx = hit_idx;
    case (cmd_i.op)
      OP_HIT, OP_REMOVE, OP_DROP_DUP: drop_en = 1'b1;
      OP_EVICT: begin
        drop_en  = 1'b1;
        drop_idx = old_idx;
      end
      OP_SCAN: begin
        drop_idx = scan_q;
        drop_en  = vld_q[scan_q] && cli_q[scan_q] == app_q;
      end
      default: drop_en = 1'b0;
    endcase
  end

  assign place_en  = (cmd_i.op == OP_PLACE);
  assign drop_age  = age_q[drop_idx];
  assign drop_size = sz_q[drop_idx];
  assign bytes_sub = (bytes_q >= {7'd0, drop_size}) ? bytes_q - {7'd0, drop_size} : '0;

  always_comb begin
    vld_d   = vld_q;
    age_d   = age_q;
    cnt_d   = cnt_q;
    bytes_d = bytes_q;
    if (drop_en) begin
      for (int i = 0; i < ENTRIES; i++)
        if (vld_q[i] && age_q[i] > drop_age) age_d[i] = age_q[i] - 1'b1;
      if (cmd_i.op == OP_HIT) begin
        // move to the newest end; bytes come back unchanged
        age_d[drop_idx] = IDX_W'(cnt_q - 1'b1);
        bytes_d = bytes_sub + {7'd0, drop_size};
      end else begin
        vld_d[drop_idx] = 1'b0;
        cnt_d   = cnt_q - 1'b1;
        bytes_d = bytes_sub;
      end
    end
    if (place_en) begin
      vld_d[free_idx] = 1'b1;
      age_d[free_idx] = IDX_W'(cnt_q);
      cnt_d   = cnt_q + 1'b1;
      bytes_d = bytes_q + {7'd0, size_q};
    end
  end

  always_comb begin
    live_d = live_q;
    next_d = next_q;
    scan_d = scan_q;
    if (cmd_i.op == OP_LATCH) scan_d = '0;
    if (cmd_i.op == OP_SCAN)  scan_d = scan_q + 1'b1;
    if (cmd_i.op == OP_KILL)  live_d[app_m1[CL_W-1:0]] = 1'b0;
    if (cmd_i.op == OP_CREATE && next_ok) begin
      live_d[next_m1[CL_W-1:0]] = 1'b1;
      next_d = next_q + 4'd1;
    end
  end

  always_comb begin
    out_load = 1'b1;
    ost   = ST_DONE;
    oapp  = '0;
    ox    = '0;
    oy    = '0;
    oz    = '0;
    ores  = '0;
    olast = 1'b1;
    case (cmd_i.op)
      OP_REPLY: ost = cmd_i.st;
      OP_CREATE: begin
        ost  = next_ok ? ST_DONE : ST_NOFREE;
        oapp = next_ok ? next_q : 4'd0;
      end
      OP_HIT, OP_REMOVE, OP_KILL, OP_PLACE: ost = ST_DONE;
      OP_EVICT: begin
        ost   = ST_EVICT;
        oapp  = cli_q[old_idx];
        ox    = ox_q[old_idx];
        oy    = oy_q[old_idx];
        oz    = oz_q[old_idx];
        ores  = lv_q[old_idx];
        olast = 1'b0;
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      live_q      <= '0;
      next_q      <= 4'd1;
      bytes_q     <= '0;
      cnt_q       <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      vld_q   <= vld_d;
      live_q  <= live_d;
      next_q  <= next_d;
      bytes_q <= bytes_d;
      cnt_q   <= cnt_d;
      scan_q  <= scan_d;
      if (out_load)          out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    age_q <= age_d;
    if (cmd_i.op == OP_LATCH) begin
      kind_q <= kind_i;
      app_q  <= app_id_i;
      x_q    <= tile_x_i;
      y_q    <= tile_y_i;
      z_q    <= tile_z_i;
      lvl_q  <= res_level_i;
      size_q <= tile_bytes_i;
    end
    if (place_en) begin
      cli_q[free_idx] <= app_q;
      ox_q[free_idx]  <= x_q;
      oy_q[free_idx]  <= y_q;
      oz_q[free_idx]  <= z_q;
      lv_q[free_idx]  <= lvl_q;
      sz_q[free_idx]  <= size_q;
    end
    if (out_load) begin
      st_q   <= ost;
      oapp_q <= oapp;
      ox_o_q <= ox;
      oy_o_q <= oy;
      oz_o_q <= oz;
      ores_q <= ores;
      used_q <= bytes_d;
      last_q <= olast;
    end
  end

  assign stat_o.out_free  = out_free;
  assign stat_o.kind      = kind_q;
  assign stat_o.client_ok = client_ok;
  assign stat_o.hit       = hit;
  assign stat_o.too_big   = {7'd0, size_q} > max_bytes_i;
  assign stat_o.over      = ({1'b0, bytes_q} + {8'd0, size_q}) > {1'b0, max_bytes_i};
  assign stat_o.empty     = (cnt_q == '0);
  assign stat_o.full      = (cnt_q == CNT_W'(ENTRIES));
  assign stat_o.scan_last = (scan_q == IDX_W'(ENTRIES - 1));

  assign out_valid_o  = out_valid_q;
  assign status_o     = st_q;
  assign out_app_o    = oapp_q;
  assign out_x_o      = ox_o_q;
  assign out_y_o      = oy_o_q;
  assign out_z_o      = oz_o_q;
  assign out_res_o    = ores_q;
  assign used_bytes_o = used_q;
  assign last_o       = last_q;

endmodule

// File: src/byte_budget_lru_tile_tracker_unit.sv
// Usage:
// Requests (lookup, insert, remove, delete client, create client) enter on the
// input channel: a word is taken when in_valid_i is high and in_stall_o low.
// Results leave on the output channel, one word per handshake; the last word
// of a request has last_o set, earlier words of an insert are eviction reports.
// Kinds 5 to 7 give no result.
// One request at a time: in_stall_o stays high from acceptance until its last
// result is loaded into the output register, and the next word can be taken
// in the cycle after that. A lookup, remove, create or rejected request loads
// its result in the decode state once the output register is free; an insert
// loads one eviction report per eviction, then its last word in the place
// state; delete client walks the 16-entry table one entry a cycle, then loads
// its result in the kill state. The table is searched in parallel each cycle.
// A stalled output holds its word and the sequencer waits on it; a new word is
// loaded in the cycle the old one is taken. Reset empties the table, forgets
// all clients, clears the byte count and sets the budget to 80 MiB. The user
// writes the budget over APB only while idle; the block does not enforce it.
module byte_budget_lru_tile_tracker_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        kind_i,
  input  logic [3:0]        app_id_i,
  input  logic signed [31:0] tile_x_i,
  input  logic signed [31:0] tile_y_i,
  input  logic signed [31:0] tile_z_i,
  input  logic [4:0]        res_level_i,
  input  logic [24:0]       tile_bytes_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [3:0]        out_app_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [4:0]        out_res_o,
  output logic [31:0]       used_bytes_o,
  output logic              last_o
);
  import bblt_pkg::*;

  logic [31:0] max_q;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign pready = 1'b1;
  // single register: every address decodes to the budget
  assign prdata = (paddr == 2'd0) ? max_q : max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_q <= MAX_BYTES_RST;
    else if (psel && penable && pwrite && pready) max_q <= pwdata;
  end

  bblt_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  bblt_dpath u_dpath (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .stat_o      (stat),
    .max_bytes_i (max_q),
    .kind_i,
    .app_id_i,
    .tile_x_i,
    .tile_y_i,
    .tile_z_i,
    .res_level_i,
    .tile_bytes_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .out_app_o,
    .out_x_o,
    .out_y_o,
    .out_z_o,
    .out_res_o,
    .used_bytes_o,
    .last_o
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken without going busy");

  a_evict_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EVICT |-> !last_o)
    else $error("eviction report marked last");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> $past(cmd.op) != OP_EVICT)
    else $error("request ended on an eviction");

endmodule
